>>> rtl/ipd_servo_controller_macros.svh
// Assertion helpers for the servo controller.
// All of them sample on the rising edge of clk and are quiet during reset.
`ifndef IPD_SERVO_CONTROLLER_MACROS_SVH
`define IPD_SERVO_CONTROLLER_MACROS_SVH

// Same-cycle implication
`define IPD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication after a fixed number of cycles
`define IPD_ASSERT_AFTER(lbl, ante, n, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

>>> rtl/ipd_pkg.sv
`default_nettype none

package ipd_pkg;

	// Parameter defaults
	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int ACC_WIDTH_DEF   = 32;

	// Fixed field widths
	localparam int FIELD_W    = 16;
	localparam int VOLT_W     = 16;
	localparam int GAIN_W     = 16;
	localparam int DB_W       = 15;
	localparam int DRIVE_W    = 17;
	localparam int DUTY_W     = 16;
	localparam int QUOT_W     = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 40;

	// Divider: three quotient bits in the first step, two in each later one
	localparam int DIV_STEPS = 7;
	localparam int DIV_CNT_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PROP     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_INTG     = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_DERIV    = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_RATE     = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND = CFG_IDX_W'(5);

	// Register reset values
	localparam logic [GAIN_W-1:0] PERIOD_RST = 16'hFFFF;
	localparam logic [GAIN_W-1:0] RATE_RST   = 16'h0001;

	// Duty of a drive at full supply, Q1.14
	localparam logic [DUTY_W-1:0] DUTY_FULL     = 16'h4000;
	localparam logic [DUTY_W-1:0] DUTY_FULL_NEG = 16'hC000;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_MUL_E,
		ST_INT,
		ST_ACC_P,
		ST_ACC_I,
		ST_ACC_D,
		ST_CLAMP,
		ST_CLR,
		ST_DIV,
		ST_DONE
	} ctrl_state_t;

	typedef enum logic [1:0] {
		MUL_ERR,
		MUL_PROP,
		MUL_INTG,
		MUL_DERIV
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_PROP,
		ACC_INTG,
		ACC_DERIV
	} acc_op_t;

	typedef struct packed {
		logic     load;
		logic     calc_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     int_upd;
		acc_op_t  acc_op;
		logic     clamp;
		logic     clear;
		logic     div_step;
		logic     out_load;
	} ipd_cmd_t;

	typedef struct packed {
		logic div_last;
	} ipd_stat_t;

endpackage

`default_nettype wire

>>> rtl/ipd_div.sv
`default_nettype none

// Restoring divider for the duty: |num| * 2^14 / den, truncated toward zero.
// Relies on |num| <= den, so the quotient never exceeds 2^14.
module ipd_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic                               step,
	input  logic signed [ipd_pkg::DRIVE_W-1:0] num,
	input  logic        [ipd_pkg::VOLT_W-1:0]  den,
	output logic signed [ipd_pkg::DUTY_W-1:0]  quot,
	output logic                               last
);
	import ipd_pkg::*;

	logic [VOLT_W-1:0]    rem_q;
	logic [VOLT_W-1:0]    den_q;
	logic [QUOT_W-1:0]    q_q;
	logic                 neg_q;
	logic                 zero_q;
	logic                 first_q;
	logic [DIV_CNT_W-1:0] cnt_q;

	logic [DRIVE_W-1:0] num_abs;
	logic [VOLT_W:0]    t0, t1, t2;
	logic [VOLT_W-1:0]  r0;
	logic [QUOT_W-1:0]  q_nxt;

	// One compare-and-subtract: quotient bit on top, remainder below
	function automatic logic [VOLT_W:0] trial(input logic [VOLT_W:0] r,
			input logic [VOLT_W-1:0] d);
		logic [VOLT_W:0] diff;
		diff = r - {1'b0, d};
		if (r >= {1'b0, d}) begin
			return {1'b1, diff[VOLT_W-1:0]};
		end
		return {1'b0, r[VOLT_W-1:0]};
	endfunction

	assign num_abs = num[DRIVE_W-1] ? DRIVE_W'(-num) : DRIVE_W'(num);

	// First step also takes the unshifted bit of weight 2^14
	always_comb begin
		t0    = trial({1'b0, rem_q}, den_q);
		r0    = first_q ? t0[VOLT_W-1:0] : rem_q;
		t1    = trial({r0, 1'b0}, den_q);
		t2    = trial({t1[VOLT_W-1:0], 1'b0}, den_q);
		q_nxt = first_q ? {q_q[QUOT_W-4:0], t0[VOLT_W], t1[VOLT_W], t2[VOLT_W]}
		                : {q_q[QUOT_W-3:0], t1[VOLT_W], t2[VOLT_W]};
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			first_q <= 1'b1;
			cnt_q   <= '0;
		end else if (step) begin
			first_q <= 1'b0;
			cnt_q   <= cnt_q + 1'b1;
		end
	end

	// Operands and partial quotient
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= num_abs[VOLT_W-1:0];
			den_q  <= den;
			neg_q  <= num[DRIVE_W-1];
			zero_q <= (den == '0);
			q_q    <= '0;
		end else if (step) begin
			rem_q <= t2[VOLT_W-1:0];
			q_q   <= q_nxt;
		end
	end

	assign last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign quot = zero_q ? '0
	            : (neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q}));

endmodule

`default_nettype wire

>>> rtl/ipd_dp.sv
`default_nettype none

// Datapath: configuration registers, controller state, one shared multiplier,
// the drive accumulator, clamp and the duty divider.
module ipd_dp #(
	parameter int ANGLE_WIDTH = ipd_pkg::ANGLE_WIDTH_DEF,
	parameter int ACC_WIDTH   = ipd_pkg::ACC_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic        [ipd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [ipd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic        [ipd_pkg::FIELD_W-1:0]   target_angle,
	input  logic        [ipd_pkg::FIELD_W-1:0]   measured_angle,
	input  logic        [ipd_pkg::VOLT_W-1:0]    supply_volts,
	input  ipd_pkg::ipd_cmd_t                    cmd,
	output ipd_pkg::ipd_stat_t                   stat,
	output logic signed [ipd_pkg::DRIVE_W-1:0]   drive_volts,
	output logic signed [ipd_pkg::DUTY_W-1:0]    duty,
	output logic                                 clamped
);
	import ipd_pkg::*;

	localparam int EW   = ANGLE_WIDTH + 1;
	localparam int MA_W = (EW > ACC_WIDTH) ? EW : ACC_WIDTH;
	localparam int MB_W = 2 * GAIN_W + 1;
	localparam int PW   = MA_W + MB_W;
	localparam int UW   = PW - 10;
	localparam int IW   = ((ACC_WIDTH > ANGLE_WIDTH + 10) ? ACC_WIDTH : ANGLE_WIDTH + 10) + 2;
	localparam int CW   = ((EW > DB_W) ? EW : DB_W) + 1;

	// Configuration
	logic [GAIN_W-1:0] prop_q, intg_q, deriv_q, period_q, rate_q;
	logic [DB_W-1:0]   db_q;

	// Controller state
	logic signed [ACC_WIDTH-1:0]   int_q;
	logic signed [ANGLE_WIDTH-1:0] prev_q;
	logic signed [DRIVE_W-1:0]     last_drive_q;
	logic        [VOLT_W-1:0]      last_supply_q;

	// Working registers
	logic signed [ANGLE_WIDTH-1:0] r_q, y_q;
	logic        [VOLT_W-1:0]      supply_q;
	logic signed [EW-1:0]          e_q, diff_q;
	logic        [2*GAIN_W-1:0]    dr_q;
	logic signed [PW-1:0]          prod_q;
	logic signed [ACC_WIDTH-1:0]   int_new_q;
	logic signed [UW-1:0]          u_q;
	logic signed [DRIVE_W-1:0]     drive_q;
	logic                          clamped_q;
	logic signed [DRIVE_W-1:0]     drive_out_q;
	logic signed [DUTY_W-1:0]      duty_out_q;
	logic                          clamped_out_q;

	// Combinational
	logic signed [EW-1:0]          e_raw, diff_raw;
	logic        [EW-1:0]          e_mag;
	logic                          e_dead;
	logic signed [MA_W-1:0]        mul_a;
	logic signed [MB_W-1:0]        mul_b;
	logic signed [PW-1:0]          prod_sh8, prod_sh12, prod_sh20;
	logic signed [IW-1:0]          int_sum;
	logic        [IW-ACC_WIDTH:0]  int_top;
	logic signed [ACC_WIDTH-1:0]   int_sat;
	logic signed [UW-1:0]          term12, term20, sup_u;
	logic signed [DRIVE_W-1:0]     drive_c;
	logic                          clamp_c;
	logic                          div_load;
	logic signed [DRIVE_W-1:0]     div_num;
	logic        [VOLT_W-1:0]      div_den;
	logic signed [DUTY_W-1:0]      div_quot;
	logic                          div_last;

	// Angle field to internal width: low bits kept when narrower, zero-extended when wider
	function automatic logic signed [ANGLE_WIDTH-1:0] to_angle(input logic [FIELD_W-1:0] f);
		logic [FIELD_W+ANGLE_WIDTH-1:0] wide;
		wide = {{ANGLE_WIDTH{1'b0}}, f};
		return wide[ANGLE_WIDTH-1:0];
	endfunction

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q   <= '0;
			intg_q   <= '0;
			deriv_q  <= '0;
			period_q <= PERIOD_RST;
			rate_q   <= RATE_RST;
			db_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PROP:     prop_q   <= cfg_data;
				CFG_INTG:     intg_q   <= cfg_data;
				CFG_DERIV:    deriv_q  <= cfg_data;
				CFG_PERIOD:   period_q <= cfg_data;
				CFG_RATE:     rate_q   <= cfg_data;
				CFG_DEADBAND: db_q     <= cfg_data[DB_W-1:0];
				default: ;
			endcase
		end
	end

	// Error with deadband, angle difference
	always_comb begin
		e_raw    = EW'(r_q) - EW'(y_q);
		e_mag    = e_raw[EW-1] ? EW'(-e_raw) : EW'(e_raw);
		e_dead   = (CW'(e_mag) < CW'(db_q));
		diff_raw = EW'(y_q) - EW'(prev_q);
	end

	// Shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MUL_ERR: begin
				mul_a = MA_W'(e_q);
				mul_b = $signed(MB_W'(period_q));
			end
			MUL_PROP: begin
				mul_a = MA_W'(y_q);
				mul_b = $signed(MB_W'(prop_q));
			end
			MUL_INTG: begin
				mul_a = MA_W'(int_new_q);
				mul_b = $signed(MB_W'(intg_q));
			end
			MUL_DERIV: begin
				mul_a = MA_W'(diff_q);
				mul_b = $signed(MB_W'(dr_q));
			end
			default: begin
				mul_a = MA_W'(e_q);
				mul_b = $signed(MB_W'(period_q));
			end
		endcase
	end

	// Scaled products; arithmetic shift gives the floor
	always_comb begin
		prod_sh8  = prod_q >>> 8;
		prod_sh12 = prod_q >>> 12;
		prod_sh20 = prod_q >>> 20;
		term12    = $signed(prod_sh12[UW-1:0]);
		term20    = $signed(prod_sh20[UW-1:0]);
	end

	// Integral add with saturation at the accumulator width
	always_comb begin
		int_sum = IW'(int_q) + $signed(prod_sh8[IW-1:0]);
		int_top = int_sum[IW-1:ACC_WIDTH-1];
		if ((&int_top) || !(|int_top)) begin
			int_sat = int_sum[ACC_WIDTH-1:0];
		end else if (int_sum[IW-1]) begin
			int_sat = {1'b1, {(ACC_WIDTH-1){1'b0}}};
		end else begin
			int_sat = {1'b0, {(ACC_WIDTH-1){1'b1}}};
		end
	end

	// Clamp to the supply; equality passes
	always_comb begin
		sup_u = $signed(UW'(supply_q));
		if (u_q > sup_u) begin
			drive_c = $signed({1'b0, supply_q});
			clamp_c = 1'b1;
		end else if (u_q < -sup_u) begin
			drive_c = -$signed({1'b0, supply_q});
			clamp_c = 1'b1;
		end else begin
			drive_c = u_q[DRIVE_W-1:0];
			clamp_c = 1'b0;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			r_q      <= to_angle(target_angle);
			y_q      <= to_angle(measured_angle);
			supply_q <= supply_volts;
		end
		if (cmd.calc_err) begin
			e_q    <= e_dead ? '0 : e_raw;
			diff_q <= diff_raw;
			dr_q   <= deriv_q * rate_q;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.int_upd) begin
			int_new_q <= int_sat;
		end
		case (cmd.acc_op)
			ACC_PROP:  u_q <= -term12;
			ACC_INTG:  u_q <= u_q + term20;
			ACC_DERIV: u_q <= u_q - term12;
			default: ;
		endcase
		if (cmd.clamp) begin
			drive_q   <= drive_c;
			clamped_q <= clamp_c;
		end else if (cmd.clear) begin
			drive_q   <= last_drive_q;
			clamped_q <= 1'b0;
		end
		if (cmd.out_load) begin
			drive_out_q   <= drive_q;
			duty_out_q    <= div_quot;
			clamped_out_q <= clamped_q;
		end
	end

	// Controller state; a clamped step keeps the old integral
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q         <= '0;
			prev_q        <= '0;
			last_drive_q  <= '0;
			last_supply_q <= '0;
		end else if (cmd.clamp) begin
			if (!clamp_c) begin
				int_q <= int_new_q;
			end
			prev_q        <= y_q;
			last_drive_q  <= drive_c;
			last_supply_q <= supply_q;
		end else if (cmd.clear) begin
			int_q <= '0;
		end
	end

	// Duty divider
	assign div_load = cmd.clamp | cmd.clear;
	assign div_num  = cmd.clamp ? drive_c : last_drive_q;
	assign div_den  = cmd.clamp ? supply_q : last_supply_q;

	ipd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.step   (cmd.div_step),
		.num    (div_num),
		.den    (div_den),
		.quot   (div_quot),
		.last   (div_last)
	);

	assign stat.div_last = div_last;
	assign drive_volts   = drive_out_q;
	assign duty          = duty_out_q;
	assign clamped       = clamped_out_q;

endmodule

`default_nettype wire

>>> rtl/ipd_ctrl.sv
`default_nettype none

// Sequencer: walks one item through the datapath and owns the handshakes.
module ipd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                op,
	input  logic                m_tready,
	input  ipd_pkg::ipd_stat_t  stat,
	output logic                s_tready,
	output logic                m_tvalid,
	output ipd_pkg::ipd_cmd_t   cmd
);
	import ipd_pkg::*;

	ctrl_state_t state_q, state_nxt;
	logic        out_valid_q;
	logic        out_free;

	// Output register can take a new result
	assign out_free = !out_valid_q || m_tready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (s_tvalid) state_nxt = op ? ST_CLR : ST_ERR;
			ST_ERR:   state_nxt = ST_MUL_E;
			ST_MUL_E: state_nxt = ST_INT;
			ST_INT:   state_nxt = ST_ACC_P;
			ST_ACC_P: state_nxt = ST_ACC_I;
			ST_ACC_I: state_nxt = ST_ACC_D;
			ST_ACC_D: state_nxt = ST_CLAMP;
			ST_CLAMP: state_nxt = ST_DIV;
			ST_CLR:   state_nxt = ST_DIV;
			ST_DIV:   if (stat.div_last) state_nxt = ST_DONE;
			ST_DONE:  if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_ERR: cmd.calc_err = 1'b1;
			ST_MUL_E: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_ERR;
			end
			ST_INT: begin
				cmd.int_upd = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PROP;
			end
			ST_ACC_P: begin
				cmd.acc_op  = ACC_PROP;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INTG;
			end
			ST_ACC_I: begin
				cmd.acc_op  = ACC_INTG;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DERIV;
			end
			ST_ACC_D: cmd.acc_op   = ACC_DERIV;
			ST_CLAMP: cmd.clamp    = 1'b1;
			ST_CLR:   cmd.clear    = 1'b1;
			ST_DIV:   cmd.div_step = 1'b1;
			ST_DONE:  cmd.out_load = out_free;
			default: ;
		endcase
	end

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/ipd_servo_controller.sv
// I-PD servo position controller with anti-windup.
// Input stream: s_tuser selects the transaction kind (0 control step, 1 integral
// clear); s_tdata carries target angle, measured angle and supply voltage.
// Output stream: m_tdata carries the clamped drive and the duty, m_tuser flags
// a drive that was limited to the supply. One result per input transaction.
// Gains, period, rate and deadband are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the block is idle; the block does not enforce this.
// A control step runs from acceptance to m_tvalid through the error and
// multiply-accumulate states on one shared multiplier, a clamp state, the
// duty divider and the output load. A clear runs through a clear state, the
// duty divider and the output load. s_tready is high only in the idle state,
// so one item is in flight at a time.
// A finished result sits in the output register; a new item may be accepted
// while it waits, and the next result is held back until m_tready takes it.
// Reset clears the integral, the previous angle, the last drive and supply, and
// loads the register defaults (period all ones, rate one, the rest zero).
`default_nettype none

module ipd_servo_controller #(
	parameter int ANGLE_WIDTH = ipd_pkg::ANGLE_WIDTH_DEF,
	parameter int ACC_WIDTH   = ipd_pkg::ACC_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [ipd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ipd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [ipd_pkg::S_TDATA_W-1:0]    s_tdata,  // target_angle, measured_angle, supply_volts
	input  logic [0:0]                       s_tuser,  // op
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [ipd_pkg::M_TDATA_W-1:0]    m_tdata,  // drive_volts, duty, zero pad
	output logic [0:0]                       m_tuser   // clamped
);
	import ipd_pkg::*;

	`include "ipd_servo_controller_macros.svh"

	ipd_cmd_t                  cmd;
	ipd_stat_t                 stat;
	logic signed [DRIVE_W-1:0] drive_volts;
	logic signed [DUTY_W-1:0]  duty;
	logic                      clamped;
	logic                      s_fire;

	assign s_fire = s_tvalid && s_tready;

	ipd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.op       (s_tuser[0]),
		.m_tready (m_tready),
		.stat     (stat),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	ipd_dp #(
		.ANGLE_WIDTH (ANGLE_WIDTH),
		.ACC_WIDTH   (ACC_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.target_angle   (s_tdata[15:0]),
		.measured_angle (s_tdata[31:16]),
		.supply_volts   (s_tdata[47:32]),
		.cmd            (cmd),
		.stat           (stat),
		.drive_volts    (drive_volts),
		.duty           (duty),
		.clamped        (clamped)
	);

	// Output packing
	assign m_tdata = {{(M_TDATA_W - DRIVE_W - DUTY_W){1'b0}}, duty, drive_volts};
	assign m_tuser = clamped;

	// With the output register empty, an accepted step offers its result at the end of its state sequence
	`IPD_ASSERT_AFTER(a_step_latency, s_fire && !s_tuser[0] && !m_tvalid, 16, m_tvalid,
		"step result not offered in time")

	// With the output register empty, an accepted clear offers its result at the end of its state sequence
	`IPD_ASSERT_AFTER(a_clear_latency, s_fire && s_tuser[0] && !m_tvalid, 10, m_tvalid,
		"clear result not offered in time")

	// A limited drive sits at full supply, so its duty is full scale or zero supply
	`IPD_ASSERT_NOW(a_clamp_duty, m_tvalid && m_tuser[0],
		m_tdata[32:17] == DUTY_FULL || m_tdata[32:17] == DUTY_FULL_NEG ||
		m_tdata[32:17] == '0,
		"clamped drive with partial duty")

	// The sequencer issues one phase command at a time
	`IPD_ASSERT_NOW(a_cmd_onehot, 1'b1,
		$onehot0({cmd.load, cmd.clamp, cmd.clear, cmd.div_step, cmd.out_load}),
		"overlapping sequencer commands")

endmodule

`default_nettype wire
